>>> src/tms_pkg.sv
// Shared types and codes for the timestamp merge scheduler.
package tms_pkg;

  localparam int STAMP_W = 64;
  localparam int PORT_W  = 3;
  localparam int TAG_W   = 16;
  localparam int FILL_W  = 7;

  // One held packet entry.
  typedef struct packed {
    logic [STAMP_W-1:0] stamp;
    logic [PORT_W-1:0]  port;
    logic [TAG_W-1:0]   tag;
  } entry_t;

  // Operation broadcast to every cell.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'b00,
    OP_INSERT = 2'b01,
    OP_POP    = 2'b10
  } cell_op_t;

  // Control word broadcast along the row of cells.
  typedef struct packed {
    cell_op_t op;
    entry_t   item;
  } cell_ctrl_t;

endpackage

>>> src/timestamp_merge_scheduler.sv
// Top level: k-way timestamp merge built on a sorted row of cells.
//
//   channel | handshake            | fields
//   in      | in_valid / in_ready  | kind, port, stamp, tag
//   out     | out_valid / out_ready| accepted, emitted, out_port, out_stamp,
//           |                      | out_tag, ordered_flag, fill
//
// The row of cells keeps the entries sorted, so cell 0 always holds the
// earliest entry and an offer or pull updates every cell in parallel at the
// accept edge. The result is registered and shown in the cycle after the
// accept; a new item is taken while the output register is empty or being
// drained, so the rate is one item per cycle while the output drains.
// Reset empties the store, restores all port credits and sets the flag.
// A stalled output holds its result and stops input acceptance.
module timestamp_merge_scheduler
  import tms_pkg::*;
#(
  parameter int PORTS          = 8,
  parameter int PER_PORT_DEPTH = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [PORT_W-1:0]  port,
  input  logic [STAMP_W-1:0] stamp,
  input  logic [TAG_W-1:0]   tag,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               accepted,
  output logic               emitted,
  output logic [PORT_W-1:0]  out_port,
  output logic [STAMP_W-1:0] out_stamp,
  output logic [TAG_W-1:0]   out_tag,
  output logic               ordered_flag,
  output logic [FILL_W-1:0]  fill
);

  localparam int CAP = PORTS * PER_PORT_DEPTH;
  localparam int NW  = $clog2(CAP + 1);
  localparam int PW  = $clog2(PORTS);
  localparam int CW  = $clog2(PER_PORT_DEPTH + 1);

  logic [NW-1:0]      count;
  logic [NW-1:0]      count_next;
  logic [CW-1:0]      credit [PORTS];
  logic [PORTS-1:0]   credit_nz;
  logic [STAMP_W-1:0] last_stamp;
  logic               in_sequence;
  logic               in_sequence_next;

  logic               take;
  logic               port_ok;
  logic               do_insert;
  logic               do_pop;
  logic [PW-1:0]      port_idx;
  logic [PW-1:0]      pop_idx;
  cell_ctrl_t         ctrl;

  logic [CAP-1:0]     occ;
  logic [CAP-1:0]     keep;
  entry_t             held [CAP];
  entry_t             pick;

  // Input handshake: output register empty or draining.
  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  // Decode the item.
  assign port_idx  = PW'(port);
  assign port_ok   = (32'(port) < PORTS);
  assign do_insert = take && !kind && port_ok && credit_nz[port_idx] &&
                     (count < NW'(CAP));
  assign do_pop    = take && kind && (count != '0);
  assign pick      = held[0];
  assign pop_idx   = PW'(pick.port);

  always_comb begin
    ctrl.item.stamp = stamp;
    ctrl.item.port  = port;
    ctrl.item.tag   = tag;
    if (do_insert) begin
      ctrl.op = OP_INSERT;
    end else if (do_pop) begin
      ctrl.op = OP_POP;
    end else begin
      ctrl.op = OP_HOLD;
    end
  end

  // Row of cells, cell 0 holds the earliest entry.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_k;

    assign occ[i] = NW'(i) < count;

    if (i == 0) begin : g_first
      assign prev_e = ctrl.item;
      assign prev_k = 1'b1;
    end else begin : g_rest
      assign prev_e = held[i-1];
      assign prev_k = keep[i-1];
    end

    if (i == CAP - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = held[i+1];
    end

    tms_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occ        (occ[i]),
      .prev_keep  (prev_k),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .keep       (keep[i]),
      .held       (held[i])
    );
  end

  // Advance the fill count.
  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + NW'(1);
    end else if (do_pop) begin
      count_next = count - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Per-port credits: take one on insert, give one back on pop.
  for (genvar p = 0; p < PORTS; p++) begin : g_credit
    assign credit_nz[p] = (credit[p] != '0);

    always_ff @(posedge clk) begin
      if (rst) begin
        credit[p] <= CW'(PER_PORT_DEPTH);
      end else if (do_insert && (port_idx == PW'(p))) begin
        credit[p] <= credit[p] - CW'(1);
      end else if (do_pop && (pop_idx == PW'(p)) &&
                   (credit[p] < CW'(PER_PORT_DEPTH))) begin
        credit[p] <= credit[p] + CW'(1);
      end
    end
  end

  // Track order of nonzero emitted stamps.
  always_comb begin
    in_sequence_next = in_sequence;
    if (do_pop && (pick.stamp != '0) && (last_stamp != '0) &&
        (pick.stamp < last_stamp)) begin
      in_sequence_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp  <= '0;
      in_sequence <= 1'b1;
    end else begin
      in_sequence <= in_sequence_next;
      if (do_pop && (pick.stamp != '0)) begin
        last_stamp <= pick.stamp;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      accepted     <= do_insert;
      emitted      <= do_pop;
      out_port     <= do_pop ? pick.port  : '0;
      out_stamp    <= do_pop ? pick.stamp : '0;
      out_tag      <= do_pop ? pick.tag   : '0;
      ordered_flag <= in_sequence_next;
      fill         <= FILL_W'(count_next);
    end
  end

endmodule

>>> src/tms_cell.sv
// One cell of the sorted systolic store: holds a single entry.
module tms_cell
  import tms_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  logic       occ,
  input  logic       prev_keep,
  input  entry_t     prev_entry,
  input  entry_t     next_entry,
  output logic       keep,
  output entry_t     held
);

  // Stay ahead of the new item when occupied and not later than it;
  // equal stamps stay ahead so ties leave in arrival order.
  assign keep = occ && (held.stamp <= ctrl.item.stamp);

  // Insert: open a gap and shift later entries down; pop: shift up.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (!keep) begin
          held <= prev_keep ? ctrl.item : prev_entry;
        end
      end
      OP_POP: begin
        held <= next_entry;
      end
      default: begin
        held <= held;
      end
    endcase
  end

endmodule

>>> dv/tb_timestamp_merge_scheduler.sv
`timescale 1ns / 1ps
// Self-checking testbench for the timestamp merge scheduler: queue-fed driver, predicting monitor.
module tb_timestamp_merge_scheduler
  import tms_pkg::*;
();

  localparam int PORT_CNT   = 8;
  localparam int PORT_DEPTH = 8;
  localparam int STORE_CAP  = PORT_CNT * PORT_DEPTH;

  localparam logic KIND_OFFER = 1'b0;
  localparam logic KIND_PULL  = 1'b1;

  localparam int STYLE_WIDE   = 0;
  localparam int STYLE_NARROW = 1;
  localparam int STYLE_RISING = 2;

  localparam int RANDOM_ITEMS    = 1150;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int IDLE_LIMIT      = 3000;
  localparam int DRAIN_CYCLES    = 20;

  localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

  typedef struct {
    logic               kind;
    logic [PORT_W-1:0]  port;
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
    bit                 wait_drain;
  } sched_item_t;

  typedef struct {
    logic               accepted;
    logic               emitted;
    logic [PORT_W-1:0]  port;
    logic [STAMP_W-1:0] stamp;
    logic [TAG_W-1:0]   tag;
    logic               flag;
    logic [FILL_W-1:0]  fill;
  } merge_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               kind = KIND_OFFER;
  logic [PORT_W-1:0]  port = '0;
  logic [STAMP_W-1:0] stamp = '0;
  logic [TAG_W-1:0]   tag = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               accepted;
  logic               emitted;
  logic [PORT_W-1:0]  out_port;
  logic [STAMP_W-1:0] out_stamp;
  logic [TAG_W-1:0]   out_tag;
  logic               ordered_flag;
  logic [FILL_W-1:0]  fill;

  timestamp_merge_scheduler #(
    .PORTS          (PORT_CNT),
    .PER_PORT_DEPTH (PORT_DEPTH)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .port         (port),
    .stamp        (stamp),
    .tag          (tag),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .accepted     (accepted),
    .emitted      (emitted),
    .out_port     (out_port),
    .out_stamp    (out_stamp),
    .out_tag      (out_tag),
    .ordered_flag (ordered_flag),
    .fill         (fill)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted scheduler state
  logic [STAMP_W-1:0] held_stamp [STORE_CAP];
  logic [PORT_W-1:0]  held_port  [STORE_CAP];
  logic [TAG_W-1:0]   held_tag   [STORE_CAP];
  logic [31:0]        held_seq   [STORE_CAP];
  int                 held_cnt = 0;
  int                 port_credit [PORT_CNT];
  logic [31:0]        next_seq = '0;
  logic [STAMP_W-1:0] last_emit_stamp = '0;
  logic               in_order = 1'b1;

  sched_item_t   offer_pull_q [$];
  merge_result_t merge_out_q [$];

  int mismatches = 0;
  int n_stored = 0, n_rejected = 0, n_emitted = 0, n_empty = 0;
  int n_checked = 0, peak_fill = 0;

  initial begin
    for (int p = 0; p < PORT_CNT; p++) port_credit[p] = PORT_DEPTH;
  end

  // Apply one accepted item to the predicted state and queue its result.
  function automatic void merge_step(logic k, logic [PORT_W-1:0] p,
                                     logic [STAMP_W-1:0] s, logic [TAG_W-1:0] t);
    merge_result_t r;
    int            best;
    int            i;
    logic [31:0]   seq_diff;
    r = '{accepted: 1'b0, emitted: 1'b0, port: '0, stamp: '0, tag: '0,
          flag: 1'b0, fill: '0};
    if (k == KIND_OFFER) begin
      if (port_credit[p] > 0 && held_cnt < STORE_CAP) begin
        held_stamp[held_cnt] = s;
        held_port[held_cnt]  = p;
        held_tag[held_cnt]   = t;
        held_seq[held_cnt]   = next_seq;
        next_seq             = next_seq + 1;
        held_cnt++;
        port_credit[p]--;
        r.accepted = 1'b1;
        n_stored++;
      end else begin
        n_rejected++;
      end
    end else if (held_cnt > 0) begin
      // Pick the earliest stamp; ties go to the older arrival, with wrap-around
      best = 0;
      for (i = 1; i < held_cnt; i++) begin
        seq_diff = held_seq[i] - held_seq[best];
        if (held_stamp[i] < held_stamp[best] ||
            (held_stamp[i] == held_stamp[best] && seq_diff[31]))
          best = i;
      end
      r.emitted = 1'b1;
      r.port    = held_port[best];
      r.stamp   = held_stamp[best];
      r.tag     = held_tag[best];
      // Move the last entry into the freed slot
      held_cnt--;
      held_stamp[best] = held_stamp[held_cnt];
      held_port[best]  = held_port[held_cnt];
      held_tag[best]   = held_tag[held_cnt];
      held_seq[best]   = held_seq[held_cnt];
      // Zero stamps carry no time and leave the order tracking alone
      if (r.stamp != '0) begin
        if (last_emit_stamp != '0 && r.stamp < last_emit_stamp) in_order = 1'b0;
        last_emit_stamp = r.stamp;
      end
      if (port_credit[r.port] < PORT_DEPTH) port_credit[r.port]++;
      n_emitted++;
    end else begin
      n_empty++;
    end
    r.flag = in_order;
    r.fill = held_cnt[FILL_W-1:0];
    if (held_cnt > peak_fill) peak_fill = held_cnt;
    merge_out_q.push_back(r);
  endfunction

  // Idle length after an item: mostly short, a few long, none in a calm stretch.
  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: mismatch on %s: expected %0h, actual %0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic add_item(logic k, logic [PORT_W-1:0] p, logic [STAMP_W-1:0] s,
                          logic [TAG_W-1:0] t, bit wait_drain);
    sched_item_t it;
    it.kind       = k;
    it.port       = p;
    it.stamp      = s;
    it.tag        = t;
    it.wait_drain = wait_drain;
    offer_pull_q.push_back(it);
  endtask

  // Driver: advance through the item queue with random gaps
  int          send_gap = 0;
  int          send_count = 0;
  bit          send_calm = 1'b0;
  sched_item_t send_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        merge_step(kind, port, stamp, tag);
        send_count++;
        if (send_count % 64 == 0) send_calm = ($urandom_range(0, 3) == 0);
        send_gap = pick_gap(send_calm);
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (offer_pull_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (offer_pull_q[0].wait_drain && merge_out_q.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          send_item = offer_pull_q.pop_front();
          in_valid  <= 1'b1;
          kind      <= send_item.kind;
          port      <= send_item.port;
          stamp     <= send_item.stamp;
          tag       <= send_item.tag;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest prediction
  int            recv_gap = 0;
  int            hold_cnt = 0;
  bit            recv_calm = 1'b0;
  merge_result_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (merge_out_q.size() == 0) begin
          $display("%0t: result with no prediction waiting", $time);
          mismatches++;
        end else begin
          want = merge_out_q.pop_front();
          check_field("accepted", 64'(want.accepted), 64'(accepted));
          check_field("emitted", 64'(want.emitted), 64'(emitted));
          check_field("out_port", 64'(want.port), 64'(out_port));
          check_field("out_stamp", want.stamp, out_stamp);
          check_field("out_tag", 64'(want.tag), 64'(out_tag));
          check_field("ordered_flag", 64'(want.flag), 64'(ordered_flag));
          check_field("fill", 64'(want.fill), 64'(fill));
        end
        n_checked++;
        if (n_checked % 64 == 0) recv_calm = ($urandom_range(0, 3) == 0);
        // Hold off long enough for the scheduler to back up its input
        if (n_checked == 300 || n_checked == 900) hold_cnt = HOLD_OFF_CYCLES;
        else recv_gap = pick_gap(recv_calm);
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no item moves for too long
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    int                 total;
    int                 seg;
    int                 seg_len;
    int                 offer_pct;
    int                 style;
    int                 j;
    bit                 drain;
    logic [STAMP_W-1:0] s;
    logic [STAMP_W-1:0] rise;

    // Directed: empty pull, field extremes, ties, zero stamp, credit exhaustion
    add_item(KIND_PULL, 3'd0, '0, '0, 1'b0);
    add_item(KIND_OFFER, 3'd0, '0, 16'h0000, 1'b0);
    add_item(KIND_OFFER, 3'd7, STAMP_MAX, 16'hFFFF, 1'b0);
    add_item(KIND_OFFER, 3'd3, 64'd100, 16'h0001, 1'b0);
    add_item(KIND_OFFER, 3'd5, 64'd100, 16'h0002, 1'b0);
    add_item(KIND_OFFER, 3'd2, 64'd100, 16'h0003, 1'b0);
    add_item(KIND_OFFER, 3'd1, 64'd50, 16'h0004, 1'b0);
    for (j = 0; j < 7; j++) add_item(KIND_PULL, 3'd7, STAMP_MAX, 16'hFFFF, 1'b0);
    for (j = 0; j < 9; j++) add_item(KIND_OFFER, 3'd6, 64'd7, TAG_W'(16'h0100 + j), 1'b0);
    // A stamp below the maximum already emitted drops the order flag
    add_item(KIND_PULL, 3'd0, '0, '0, 1'b0);

    // Random segments with varying offer mix and stamp style
    total = 0;
    seg   = 0;
    rise  = 64'd1000;
    while (total < RANDOM_ITEMS) begin
      seg_len = $urandom_range(20, 80);
      case ($urandom_range(0, 2))
        0:       offer_pct = 25;
        1:       offer_pct = 50;
        default: offer_pct = 85;
      endcase
      style = $urandom_range(0, 2);
      for (j = 0; j < seg_len; j++) begin
        drain = (j == 0 && seg % 4 == 0);
        if ($urandom_range(0, 99) < offer_pct) begin
          case (style)
            STYLE_WIDE:   s = {$urandom, $urandom};
            STYLE_NARROW: s = STAMP_W'($urandom_range(0, 15));
            default: begin
              rise = rise + STAMP_W'($urandom_range(0, 3));
              s    = rise;
            end
          endcase
          if ($urandom_range(0, 19) == 0) s = '0;
          add_item(KIND_OFFER, PORT_W'($urandom_range(0, PORT_CNT - 1)), s,
                   TAG_W'($urandom_range(0, 16'hFFFF)), drain);
        end else begin
          add_item(KIND_PULL, PORT_W'($urandom_range(0, PORT_CNT - 1)),
                   {$urandom, $urandom}, TAG_W'($urandom_range(0, 16'hFFFF)), drain);
        end
        total++;
      end
      seg++;
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (offer_pull_q.size() == 0 && !in_valid);
    wait (merge_out_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results: %0d offers stored, %0d refused, %0d pulls emitted,",
             n_checked, n_stored, n_rejected, n_emitted);
    $display("%0d pulls on an empty store, peak fill %0d of %0d, %0d mismatches",
             n_empty, peak_fill, STORE_CAP, mismatches);
    if (mismatches == 0 && merge_out_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
